// ----- rtl/ics_pkg.sv -----
`timescale 1ns / 1ps

package ics_pkg;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_WIDTH  = 1'b0,
        CFG_SAMPLE_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 9'd256;

    // Pixel and result geometry
    localparam int PIX_W    = 8;
    localparam int IN_W     = 3 * PIX_W;
    localparam int COUNT_W  = 17;
    localparam int UNIQUE_W = 13;
    localparam int GSUM_W   = 25;
    localparam int OUT_W    = 176;
    localparam int PAD_W    = OUT_W - (8 * COUNT_W + UNIQUE_W + GSUM_W + 1);

    // Luma weights, sum fits 16 bits
    localparam int LSUM_W = 16;
    localparam logic [LSUM_W-1:0] LUMA_R = 16'd77;
    localparam logic [LSUM_W-1:0] LUMA_G = 16'd150;
    localparam logic [LSUM_W-1:0] LUMA_B = 16'd29;

    localparam logic [PIX_W-1:0] INK_LIMIT    = 8'd200;
    localparam logic [PIX_W-1:0] WHITE_LIMIT  = 8'd245;
    localparam logic [PIX_W-1:0] BLACK_LIMIT  = 8'd10;
    localparam logic [PIX_W-1:0] CHROMA_LIMIT = 8'd16;

    // Colour map: RGB444 key, one epoch tag per entry
    localparam int KEY_W     = 12;
    localparam int MAP_DEPTH = 4096;
    localparam int EPOCH_W   = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

    // v / 20 as (v * DIV20_MULT) >> DIV20_SHIFT, exact for v below 2**18
    localparam int DIV20_MULT_W = 16;
    localparam logic [DIV20_MULT_W-1:0] DIV20_MULT = 16'd52429;
    localparam int DIV20_SHIFT = 20;

    localparam int RATIO_W = 6;
    localparam logic [RATIO_W-1:0] CHROMA_RATIO = 6'd50;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma;
        logic [KEY_W-1:0] key;
    } pixel_class_t;

    // Last field in the lowest bits
    typedef struct packed {
        logic [PAD_W-1:0]    pad;
        logic                is_color;
        logic [COUNT_W-1:0]  gradient_count;
        logic [GSUM_W-1:0]   gradient_sum;
        logic [COUNT_W-1:0]  border_white_count;
        logic [COUNT_W-1:0]  border_count;
        logic [UNIQUE_W-1:0] unique_colors;
        logic [COUNT_W-1:0]  chroma_count;
        logic [COUNT_W-1:0]  black_count;
        logic [COUNT_W-1:0]  white_count;
        logic [COUNT_W-1:0]  ink_count;
        logic [COUNT_W-1:0]  pixel_count;
    } result_t;

    function automatic logic [PIX_W-1:0] abs_diff8(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ----- rtl/image_content_statistics.sv -----
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while s_tready is high; the colour map and the line store each take one
// read and one write per cycle.
// The last pixel of a frame passes through stage 1, then its result is registered and shown on m_tvalid.
// Reset: aresetn (synchronous) clears all counters and control; then a pass over every
// entry zeroes the colour map with s_tready low. The same pass runs after every 255th
// frame, when the 8-bit frame tag of the colour map wraps.
module image_content_statistics #(
    parameter int MAX_SIDE = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ics_pkg::IN_W-1:0]   s_tdata,   // red, green, blue
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pixel_count, ink_count, white_count, black_count, chroma_count, unique_colors,
    // border_count, border_white_count, gradient_sum, gradient_count, is_color
    output logic [ics_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  ics_pkg::cfg_index_t        cfg_index,
    input  logic [ics_pkg::CFG_W-1:0]  cfg_data
);
    import ics_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int XW = $clog2(MAX_SIDE);
    localparam int CW = (CFG_W > SW) ? CFG_W : SW;
    localparam int PW = 2 * SW;
    localparam int MW = SW + DIV20_MULT_W;
    localparam int RW = ((COUNT_W + RATIO_W) > PW) ? (COUNT_W + RATIO_W) : PW;
    localparam int KW = $clog2(MAP_DEPTH);

    // Configuration
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [SW-1:0]    w_eff;
    logic [SW-1:0]    h_eff;
    logic [MW-1:0]    bx_prod;
    logic [MW-1:0]    by_prod;
    logic [SW-1:0]    bx_reg;
    logic [SW-1:0]    by_reg;

    // Stage 0
    pixel_class_t     cls;
    logic             accept;
    logic [XW-1:0]    col_reg;
    logic [XW-1:0]    row_reg;
    logic [SW:0]      x_inc;
    logic [SW:0]      y_inc;
    logic             row_wrap;
    logic             frame_last;

    // Stage 1
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_luma_reg;
    logic             s1_chroma_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic [XW-1:0]    s1_x_reg;
    logic [XW-1:0]    s1_y_reg;
    logic             s1_last_reg;
    logic             s1_map_fwd_reg;
    logic             s1_line_fwd_reg;
    logic             s1_hold;
    logic             s1_done;
    logic             wrap_pending;

    // Memories
    logic [EPOCH_W-1:0] colour_map [MAP_DEPTH];
    logic [PIX_W-1:0]   line_store [MAX_SIDE];
    logic [EPOCH_W-1:0] map_rdata_reg;
    logic [PIX_W-1:0]   line_rdata_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               clear_active_reg;
    logic [KW-1:0]      clear_addr_reg;

    // Totals
    logic [PIX_W-1:0]    prev_luma_reg;
    logic [COUNT_W-1:0]  ink_reg, white_reg, black_reg, chroma_reg;
    logic [COUNT_W-1:0]  border_reg, border_white_reg;
    logic [UNIQUE_W-1:0] unique_reg;
    logic [GSUM_W-1:0]   gsum_reg;
    logic [COUNT_W-1:0]  ink_next, white_next, black_next, chroma_next;
    logic [COUNT_W-1:0]  border_next, border_white_next;
    logic [UNIQUE_W-1:0] unique_next;
    logic [GSUM_W-1:0]   gsum_next;

    logic               is_white;
    logic               in_border;
    logic               seen;
    logic [PIX_W-1:0]   up_luma;
    logic [PIX_W-1:0]   horiz_step;
    logic [PIX_W-1:0]   vert_step;

    logic [PW-1:0]      pixel_total;
    logic [PW:0]        pair_total;
    logic [RW-1:0]      chroma_scaled;
    result_t            result_next;
    result_t            result_reg;
    logic               out_valid_reg;

    ics_pixel_classify u_classify (
        .pixel (s_tdata),
        .cls   (cls)
    );

    // Out-of-range sizes: zero acts as one, above MAX_SIDE acts as MAX_SIDE.
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = SW'(1);
        end else if (CW'(width_cfg_reg) > CW'(MAX_SIDE)) begin
            w_eff = SW'(MAX_SIDE);
        end else begin
            w_eff = SW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = SW'(1);
        end else if (CW'(height_cfg_reg) > CW'(MAX_SIDE)) begin
            h_eff = SW'(MAX_SIDE);
        end else begin
            h_eff = SW'(height_cfg_reg);
        end
    end

    assign bx_prod = MW'(w_eff) * MW'(DIV20_MULT);
    assign by_prod = MW'(h_eff) * MW'(DIV20_MULT);

    assign cfg_ready = 1'b1;

    // Position of the incoming pixel and whether it closes the frame.
    assign accept     = s_tvalid && s_tready;
    assign x_inc      = (SW+1)'(col_reg) + (SW+1)'(1);
    assign y_inc      = (SW+1)'(row_reg) + (SW+1)'(1);
    assign row_wrap   = x_inc >= (SW+1)'(w_eff);
    assign frame_last = row_wrap && (y_inc >= (SW+1)'(h_eff));

    assign s1_hold      = s1_last_reg && out_valid_reg && !m_tready;
    assign s1_done      = s1_valid_reg && !s1_hold;
    assign wrap_pending = s1_valid_reg && s1_last_reg && (epoch_reg == EPOCH_LAST);
    assign s_tready     = !clear_active_reg && !(s1_valid_reg && s1_hold) && !wrap_pending;

    // Stage 1: read data of both memories arrives here. Writes by the pixel that
    // left stage 1 on the accepting edge are not yet visible, so they are forwarded.
    assign seen    = (map_rdata_reg == epoch_reg) || s1_map_fwd_reg;
    assign up_luma = s1_line_fwd_reg ? prev_luma_reg : line_rdata_reg;

    assign is_white   = s1_luma_reg >= WHITE_LIMIT;
    assign horiz_step = (s1_x_reg != '0) ? abs_diff8(s1_luma_reg, prev_luma_reg) : '0;
    assign vert_step  = (s1_y_reg != '0) ? abs_diff8(s1_luma_reg, up_luma) : '0;

    assign in_border = ((SW+1)'(s1_y_reg) < (SW+1)'(by_reg))
                    || (((SW+1)'(s1_y_reg) + (SW+1)'(by_reg)) >= (SW+1)'(h_eff))
                    || ((SW+1)'(s1_x_reg) < (SW+1)'(bx_reg))
                    || (((SW+1)'(s1_x_reg) + (SW+1)'(bx_reg)) >= (SW+1)'(w_eff));

    always_comb begin
        ink_next          = ink_reg + COUNT_W'(s1_luma_reg < INK_LIMIT);
        white_next        = white_reg + COUNT_W'(is_white);
        black_next        = black_reg + COUNT_W'(s1_luma_reg <= BLACK_LIMIT);
        chroma_next       = chroma_reg + COUNT_W'(s1_chroma_reg);
        unique_next       = unique_reg + UNIQUE_W'(!seen);
        border_next       = border_reg + COUNT_W'(in_border);
        border_white_next = border_white_reg + COUNT_W'(in_border && is_white);
        gsum_next         = gsum_reg + GSUM_W'(horiz_step) + GSUM_W'(vert_step);
    end

    assign pixel_total   = PW'(w_eff) * PW'(h_eff);
    assign pair_total    = ((PW+1)'(pixel_total) << 1) - (PW+1)'(w_eff) - (PW+1)'(h_eff);
    assign chroma_scaled = RW'(chroma_next) * RW'(CHROMA_RATIO);

    always_comb begin
        result_next                    = '0;
        result_next.pixel_count        = COUNT_W'(pixel_total);
        result_next.ink_count          = ink_next;
        result_next.white_count        = white_next;
        result_next.black_count        = black_next;
        result_next.chroma_count       = chroma_next;
        result_next.unique_colors      = unique_next;
        result_next.border_count       = border_next;
        result_next.border_white_count = border_white_next;
        result_next.gradient_sum       = gsum_next;
        result_next.gradient_count     = COUNT_W'(pair_total);
        result_next.is_color           = chroma_scaled > RW'(pixel_total);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg    <= CFG_SIDE_RESET;
            height_cfg_reg   <= CFG_SIDE_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            epoch_reg        <= EPOCH_FIRST;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            prev_luma_reg    <= '0;
            ink_reg          <= '0;
            white_reg        <= '0;
            black_reg        <= '0;
            chroma_reg       <= '0;
            unique_reg       <= '0;
            border_reg       <= '0;
            border_white_reg <= '0;
            gsum_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SAMPLE_WIDTH:  width_cfg_reg  <= cfg_data;
                    CFG_SAMPLE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept) begin
                if (frame_last) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (row_wrap) begin
                    col_reg <= '0;
                    row_reg <= XW'(y_inc);
                end else begin
                    col_reg <= XW'(x_inc);
                end
            end

            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end

            if (clear_active_reg) begin
                clear_addr_reg <= clear_addr_reg + KW'(1);
                if (clear_addr_reg == KW'(MAP_DEPTH - 1)) begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (s1_done) begin
                if (s1_last_reg) begin
                    prev_luma_reg    <= '0;
                    ink_reg          <= '0;
                    white_reg        <= '0;
                    black_reg        <= '0;
                    chroma_reg       <= '0;
                    unique_reg       <= '0;
                    border_reg       <= '0;
                    border_white_reg <= '0;
                    gsum_reg         <= '0;
                    if (epoch_reg == EPOCH_LAST) begin
                        epoch_reg        <= EPOCH_FIRST;
                        clear_active_reg <= 1'b1;
                        clear_addr_reg   <= '0;
                    end else begin
                        epoch_reg <= epoch_reg + EPOCH_W'(1);
                    end
                end else begin
                    prev_luma_reg    <= s1_luma_reg;
                    ink_reg          <= ink_next;
                    white_reg        <= white_next;
                    black_reg        <= black_next;
                    chroma_reg       <= chroma_next;
                    unique_reg       <= unique_next;
                    border_reg       <= border_next;
                    border_white_reg <= border_white_next;
                    gsum_reg         <= gsum_next;
                end
            end

            if (s1_done && s1_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        bx_reg <= SW'(bx_prod >> DIV20_SHIFT) + SW'(1);
        by_reg <= SW'(by_prod >> DIV20_SHIFT) + SW'(1);
        if (accept) begin
            s1_luma_reg     <= cls.luma;
            s1_chroma_reg   <= cls.chroma;
            s1_key_reg      <= cls.key;
            s1_x_reg        <= col_reg;
            s1_y_reg        <= row_reg;
            s1_last_reg     <= frame_last;
            // A new frame starts with a new tag, so no colour map forwarding across frames.
            s1_map_fwd_reg  <= s1_done && !s1_last_reg && (cls.key == s1_key_reg);
            s1_line_fwd_reg <= s1_done && (col_reg == s1_x_reg);
        end
        if (s1_done && s1_last_reg) begin
            result_reg <= result_next;
        end
    end

    // Colour map, line store: read once on accept, written as a pixel leaves stage 1 or by the clear.
    always_ff @(posedge aclk) begin
        if (accept) begin
            map_rdata_reg  <= colour_map[cls.key];
            line_rdata_reg <= line_store[col_reg];
        end
        if (clear_active_reg) begin
            colour_map[clear_addr_reg] <= '0;
        end else if (s1_done) begin
            colour_map[s1_key_reg] <= epoch_reg;
        end
        if (s1_done) begin
            line_store[s1_x_reg] <= s1_luma_reg;
        end
    end

endmodule

// ----- rtl/ics_pixel_classify.sv -----
`timescale 1ns / 1ps

module ics_pixel_classify (
    input  logic [ics_pkg::IN_W-1:0] pixel,  // red, green, blue
    output ics_pkg::pixel_class_t    cls
);
    import ics_pkg::*;

    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [LSUM_W-1:0] luma_sum;

    assign red   = pixel[PIX_W-1:0];
    assign green = pixel[2*PIX_W-1:PIX_W];
    assign blue  = pixel[3*PIX_W-1:2*PIX_W];

    assign luma_sum = LSUM_W'({8'b0, red} * LUMA_R)
                    + LSUM_W'({8'b0, green} * LUMA_G)
                    + LSUM_W'({8'b0, blue} * LUMA_B);

    always_comb begin
        cls.luma   = luma_sum[LSUM_W-1:LSUM_W-PIX_W];
        // The largest pairwise difference exceeds the limit when any one does.
        cls.chroma = (abs_diff8(red, green) > CHROMA_LIMIT)
                  || (abs_diff8(red, blue) > CHROMA_LIMIT)
                  || (abs_diff8(green, blue) > CHROMA_LIMIT);
        cls.key    = {red[7:4], green[7:4], blue[7:4]};
    end

endmodule

// ----- rtl/ics_checker.sv -----
`timescale 1ns / 1ps

module ics_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ics_pkg::OUT_W-1:0] m_tdata   // result fields, pixel_count lowest
);
    import ics_pkg::*;

    result_t res;
    assign res = m_tdata;

    // After reset the map clear holds off input and no result is pending.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("input ready or result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // A result only appears once the transaction that closed the frame has passed through stage 1.
    a_out_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a closing input transaction");

    a_result_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.unique_colors != '0) && (!res.is_color || res.chroma_count != '0))
        else $error("result fields inconsistent");

endmodule

bind image_content_statistics ics_checker u_ics_checker (.*);
